FILE: hw/rtl/slcp_pkg.sv
// Shared constants for the skew line closest point block.
// No dependencies.
package slcp_pkg;

  localparam int unsigned POS_WIDTH_DEF = 32;
  localparam int unsigned DIR_WIDTH_DEF = 16;
  // entries in the queue between front and back
  localparam int unsigned FIFO_DEPTH    = 2;

endpackage

FILE: hw/rtl/slcp_if.sv
// Valid/ready channel interfaces for the input line pair and the hit result.
// Depends on slcp_pkg for default widths.
interface slcp_in_if #(
  parameter int unsigned POS_WIDTH = slcp_pkg::POS_WIDTH_DEF,
  parameter int unsigned DIR_WIDTH = slcp_pkg::DIR_WIDTH_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic signed [DIR_WIDTH-1:0] trk_dir_x;
  logic signed [DIR_WIDTH-1:0] trk_dir_y;
  logic signed [DIR_WIDTH-1:0] trk_dir_z;
  logic signed [POS_WIDTH-1:0] trk_pt_x;
  logic signed [POS_WIDTH-1:0] trk_pt_y;
  logic signed [POS_WIDTH-1:0] trk_pt_z;
  logic signed [DIR_WIDTH-1:0] wire_dir_x;
  logic signed [DIR_WIDTH-1:0] wire_dir_y;
  logic signed [DIR_WIDTH-1:0] wire_dir_z;
  logic signed [POS_WIDTH-1:0] wire_pt_x;
  logic signed [POS_WIDTH-1:0] wire_pt_y;
  logic signed [POS_WIDTH-1:0] wire_pt_z;

  modport source (
    output valid, trk_dir_x, trk_dir_y, trk_dir_z, trk_pt_x, trk_pt_y, trk_pt_z,
           wire_dir_x, wire_dir_y, wire_dir_z, wire_pt_x, wire_pt_y, wire_pt_z,
    input  ready
  );
  modport sink (
    input  valid, trk_dir_x, trk_dir_y, trk_dir_z, trk_pt_x, trk_pt_y, trk_pt_z,
           wire_dir_x, wire_dir_y, wire_dir_z, wire_pt_x, wire_pt_y, wire_pt_z,
    output ready
  );
endinterface

interface slcp_out_if #(
  parameter int unsigned POS_WIDTH = slcp_pkg::POS_WIDTH_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic signed [POS_WIDTH-1:0] hit_x;
  logic signed [POS_WIDTH-1:0] hit_y;
  logic signed [POS_WIDTH-1:0] hit_z;
  logic                        degenerate_flag;

  modport source (output valid, hit_x, hit_y, hit_z, degenerate_flag, input ready);
  modport sink   (input valid, hit_x, hit_y, hit_z, degenerate_flag, output ready);
endinterface

FILE: hw/rtl/slcp_mul.sv
// Two-stage signed multiplier: B is split in halves, partial products registered.
// No dependencies.
module slcp_mul #(
  parameter int unsigned AW = 34,
  parameter int unsigned BW = 51
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [AW-1:0]  a_i,
  input  logic signed [BW-1:0]  b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int unsigned LW = BW / 2;
  localparam int unsigned HW = BW - LW;

  logic signed [LW:0]       b_lo;
  logic signed [HW-1:0]     b_hi;
  logic signed [AW+LW:0]    pp_lo_q;
  logic signed [AW+HW-1:0]  pp_hi_q;
  logic signed [AW+BW-1:0]  p_q;

  // low half is unsigned, so give it a zero sign bit
  assign b_lo = $signed({1'b0, b_i[LW-1:0]});
  assign b_hi = b_i[BW-1:LW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_lo_q <= a_i * b_lo;
      pp_hi_q <= a_i * b_hi;
      p_q     <= ((AW+BW)'(pp_hi_q) <<< LW) + (AW+BW)'(pp_lo_q);
    end
  end

  assign p_o = p_q;

endmodule

FILE: hw/rtl/slcp_fifo.sv
// Short queue between the front and the back pipelines.
// Depends on slcp_pkg for the depth.
module slcp_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned DEPTH = slcp_pkg::FIFO_DEPTH;
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/slcp_front.sv
// Front pipeline: offsets, dot products, numerator and denominator.
// Depends on slcp_if, slcp_mul.
module slcp_front #(
  parameter int unsigned POS_WIDTH = 32,
  parameter int unsigned DIR_WIDTH = 16,
  parameter int unsigned FW        = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  slcp_in_if.sink        trk_i,
  output logic           push_valid_o,
  input  logic           push_ready_i,
  output logic [FW-1:0]  push_data_o
);

  localparam int unsigned P  = POS_WIDTH;
  localparam int unsigned D  = DIR_WIDTH;
  localparam int unsigned OW = P + 1;
  localparam int unsigned SW = 2 * D + 2;
  localparam int unsigned TW = D + P + 3;
  localparam int unsigned NW = 3 * D + P + 6;
  localparam int unsigned EW = 4 * D + 5;
  localparam int unsigned NF = 6;

  logic [NF-1:0] v_q;
  logic          en;

  logic signed [D-1:0]     in_a [3];
  logic signed [D-1:0]     in_b [3];
  logic signed [P-1:0]     in_wp [3];
  logic signed [P-1:0]     in_tp [3];

  logic signed [D-1:0]     wd_q [NF][3];
  logic signed [P-1:0]     wp_q [NF][3];
  logic signed [D-1:0]     b1_q [3];
  logic signed [OW-1:0]    off1_q [3];
  logic signed [2*D-1:0]   paa_q [3];
  logic signed [2*D-1:0]   pbb_q [3];
  logic signed [2*D-1:0]   pab_q [3];
  logic signed [D+OW-1:0]  pad_q [3];
  logic signed [D+OW-1:0]  pbd_q [3];
  logic signed [SW-1:0]    aa_q, bb_q, ab_q;
  logic signed [TW-1:0]    ad_q, bd_q;
  logic signed [SW+TW-1:0] p0, p1;
  logic signed [2*SW-1:0]  p2, p3;
  logic signed [NW-1:0]    num_q;
  logic signed [EW-1:0]    den_q;

  assign in_a[0]  = trk_i.wire_dir_x;
  assign in_a[1]  = trk_i.wire_dir_y;
  assign in_a[2]  = trk_i.wire_dir_z;
  assign in_b[0]  = trk_i.trk_dir_x;
  assign in_b[1]  = trk_i.trk_dir_y;
  assign in_b[2]  = trk_i.trk_dir_z;
  assign in_wp[0] = trk_i.wire_pt_x;
  assign in_wp[1] = trk_i.wire_pt_y;
  assign in_wp[2] = trk_i.wire_pt_z;
  assign in_tp[0] = trk_i.trk_pt_x;
  assign in_tp[1] = trk_i.trk_pt_y;
  assign in_tp[2] = trk_i.trk_pt_z;

  // whole pipe advances unless the last stage holds a word the queue refuses
  assign en          = !v_q[NF-1] || push_ready_i;
  assign trk_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NF-2:0], trk_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        wd_q[0][k] <= in_a[k];
        wp_q[0][k] <= in_wp[k];
        b1_q[k]    <= in_b[k];
        off1_q[k]  <= OW'(in_wp[k]) - OW'(in_tp[k]);
        for (int s = 1; s < NF; s++) begin
          wd_q[s][k] <= wd_q[s-1][k];
          wp_q[s][k] <= wp_q[s-1][k];
        end
        paa_q[k] <= wd_q[0][k] * wd_q[0][k];
        pbb_q[k] <= b1_q[k] * b1_q[k];
        pab_q[k] <= wd_q[0][k] * b1_q[k];
        pad_q[k] <= wd_q[0][k] * off1_q[k];
        pbd_q[k] <= b1_q[k] * off1_q[k];
      end
      aa_q  <= SW'(paa_q[0]) + SW'(paa_q[1]) + SW'(paa_q[2]);
      bb_q  <= SW'(pbb_q[0]) + SW'(pbb_q[1]) + SW'(pbb_q[2]);
      ab_q  <= SW'(pab_q[0]) + SW'(pab_q[1]) + SW'(pab_q[2]);
      ad_q  <= TW'(pad_q[0]) + TW'(pad_q[1]) + TW'(pad_q[2]);
      bd_q  <= TW'(pbd_q[0]) + TW'(pbd_q[1]) + TW'(pbd_q[2]);
      num_q <= NW'(p0) - NW'(p1);
      den_q <= EW'(p2) - EW'(p3);
    end
  end

  slcp_mul #(.AW(SW), .BW(TW)) u_mul_bb_ad (
    .clk_i(clk_i), .en_i(en), .a_i(bb_q), .b_i(ad_q), .p_o(p0)
  );
  slcp_mul #(.AW(SW), .BW(TW)) u_mul_ab_bd (
    .clk_i(clk_i), .en_i(en), .a_i(ab_q), .b_i(bd_q), .p_o(p1)
  );
  slcp_mul #(.AW(SW), .BW(SW)) u_mul_ab_ab (
    .clk_i(clk_i), .en_i(en), .a_i(ab_q), .b_i(ab_q), .p_o(p2)
  );
  slcp_mul #(.AW(SW), .BW(SW)) u_mul_aa_bb (
    .clk_i(clk_i), .en_i(en), .a_i(aa_q), .b_i(bb_q), .p_o(p3)
  );

  assign push_valid_o = v_q[NF-1];
  assign push_data_o  = {num_q, den_q,
                         wd_q[NF-1][0], wd_q[NF-1][1], wd_q[NF-1][2],
                         wp_q[NF-1][0], wp_q[NF-1][1], wp_q[NF-1][2]};

endmodule

FILE: hw/rtl/slcp_div.sv
// One lane of the back: restoring divide (one quotient bit per stage),
// round half away from zero, add the wire point, saturate; a zero divisor gives the wire point.
// No dependencies.
module slcp_div #(
  parameter int unsigned P  = 32,
  parameter int unsigned NW = 102,
  parameter int unsigned DW = 69
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [NW-1:0] n_i,
  input  logic signed [DW-1:0] d_i,
  input  logic signed [P-1:0]  wp_i,
  output logic signed [P-1:0]  hit_o,
  output logic                 deg_o
);

  localparam int unsigned XW  = NW + DW + P + 2;
  localparam int unsigned QW  = P + 1;
  localparam int unsigned SMW = P + 4;
  localparam int unsigned NS  = P + 2;

  logic [NW-1:0] nabs;
  logic [DW-1:0] dabs;
  logic          ovf_c;

  logic [NW-1:0]        r_q   [NS];
  logic [QW-1:0]        q_q   [NS];
  logic [DW-1:0]        dm_q  [NS];
  logic                 neg_q [NS];
  logic                 ovf_q [NS];
  logic                 deg_q [NS];
  logic signed [P-1:0]  wp_q  [NS];

  logic                  rnd;
  logic [P+1:0]          qm;
  logic signed [SMW-1:0] qs, sum;
  logic signed [P-1:0]   hit_d, hit_q;
  logic                  deg_out_q;
  logic signed [P-1:0]   pos_max, pos_min;

  assign nabs = n_i[NW-1] ? NW'(~n_i + NW'(1)) : NW'(n_i);
  assign dabs = d_i[DW-1] ? DW'(~d_i + DW'(1)) : DW'(d_i);
  // quotient at or past 2^(P+1) saturates whatever the wire point is
  assign ovf_c = XW'(nabs) >= (XW'(dabs) << (P + 1));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= nabs;
      q_q[0]   <= '0;
      dm_q[0]  <= dabs;
      neg_q[0] <= n_i[NW-1] ^ d_i[DW-1];
      ovf_q[0] <= ovf_c;
      deg_q[0] <= (d_i == '0);
      wp_q[0]  <= wp_i;
    end
  end

  for (genvar i = 0; i < P + 1; i++) begin : g_stage
    localparam int unsigned K = P - i;
    logic [XW-1:0] dsh;
    logic          ge;
    assign dsh = XW'(dm_q[i]) << K;
    assign ge  = XW'(r_q[i]) >= dsh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[i+1]   <= ge ? NW'(XW'(r_q[i]) - dsh) : r_q[i];
        q_q[i+1]   <= q_q[i] | (QW'(ge) << K);
        dm_q[i+1]  <= dm_q[i];
        neg_q[i+1] <= neg_q[i];
        ovf_q[i+1] <= ovf_q[i];
        deg_q[i+1] <= deg_q[i];
        wp_q[i+1]  <= wp_q[i];
      end
    end
  end

  assign pos_max = $signed({1'b0, {(P-1){1'b1}}});
  assign pos_min = $signed({1'b1, {(P-1){1'b0}}});

  always_comb begin
    rnd = (XW'(r_q[NS-1]) << 1) >= XW'(dm_q[NS-1]);
    qm  = (P+2)'(q_q[NS-1]) + (P+2)'(rnd);
    qs  = neg_q[NS-1] ? SMW'(0) - SMW'(qm) : SMW'(qm);
    sum = SMW'(wp_q[NS-1]) + qs;
    if (deg_q[NS-1]) begin
      hit_d = wp_q[NS-1];
    end else if (ovf_q[NS-1]) begin
      hit_d = neg_q[NS-1] ? pos_min : pos_max;
    end else if (sum[SMW-1:P-1] != {(SMW-P+1){sum[SMW-1]}}) begin
      hit_d = sum[SMW-1] ? pos_min : pos_max;
    end else begin
      hit_d = sum[P-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q     <= hit_d;
      deg_out_q <= deg_q[NS-1];
    end
  end

  assign hit_o = hit_q;
  assign deg_o = deg_out_q;

endmodule

FILE: hw/rtl/slcp_back.sv
// Back pipeline: step products, three divider lanes, output register.
// Depends on slcp_if, slcp_mul, slcp_div.
module slcp_back #(
  parameter int unsigned POS_WIDTH = 32,
  parameter int unsigned DIR_WIDTH = 16,
  parameter int unsigned FW        = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  logic [FW-1:0] pop_data_i,
  slcp_out_if.source    hit_o
);

  localparam int unsigned P  = POS_WIDTH;
  localparam int unsigned D  = DIR_WIDTH;
  localparam int unsigned NW = 3 * D + P + 6;
  localparam int unsigned EW = 4 * D + 5;
  localparam int unsigned MW = D + NW;
  localparam int unsigned LB = P + 5;

  logic [LB-1:0] vb_q;
  logic          en;

  logic signed [NW-1:0] num;
  logic signed [EW-1:0] den;
  logic signed [D-1:0]  a [3];
  logic signed [P-1:0]  wp [3];

  logic signed [EW-1:0] den_q [2];
  logic signed [P-1:0]  wp_q  [2][3];
  logic signed [MW-1:0] step [3];
  logic signed [P-1:0]  hit [3];
  logic                 deg [3];

  assign num   = pop_data_i[3*P+3*D+EW +: NW];
  assign den   = pop_data_i[3*P+3*D +: EW];
  assign a[0]  = pop_data_i[3*P+2*D +: D];
  assign a[1]  = pop_data_i[3*P+D +: D];
  assign a[2]  = pop_data_i[3*P +: D];
  assign wp[0] = pop_data_i[2*P +: P];
  assign wp[1] = pop_data_i[P +: P];
  assign wp[2] = pop_data_i[0 +: P];

  assign en          = !vb_q[LB-1] || hit_o.ready;
  assign pop_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= '0;
    end else if (en) begin
      vb_q <= {vb_q[LB-2:0], pop_valid_i};
    end
  end

  // side data rides alongside the two multiplier stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q[0] <= den;
      den_q[1] <= den_q[0];
      for (int k = 0; k < 3; k++) begin
        wp_q[0][k] <= wp[k];
        wp_q[1][k] <= wp_q[0][k];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    slcp_mul #(.AW(D), .BW(NW)) u_mul (
      .clk_i(clk_i), .en_i(en), .a_i(a[k]), .b_i(num), .p_o(step[k])
    );
    slcp_div #(.P(P), .NW(MW), .DW(EW)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .n_i   (step[k]),
      .d_i   (den_q[1]),
      .wp_i  (wp_q[1][k]),
      .hit_o (hit[k]),
      .deg_o (deg[k])
    );
  end

  assign hit_o.valid           = vb_q[LB-1];
  assign hit_o.hit_x           = hit[0];
  assign hit_o.hit_y           = hit[1];
  assign hit_o.hit_z           = hit[2] ^ {P{deg[1] & ~deg[1]}};
  assign hit_o.degenerate_flag = deg[0] | (deg[2] & deg[1]);

endmodule

FILE: hw/rtl/skew_line_closest_point.sv
// Closest point on a wire line to a track line, Q16.16 positions, Q1.14 directions.
// Throughput: one line pair per cycle unless the result sink holds ready low;
// set by the one-bit-per-stage divider pipeline.
// Reset clears only valid bits, queue pointers and count; no storage needs clearing.
// Depends on slcp_pkg, slcp_if, slcp_front, slcp_fifo, slcp_back.
module skew_line_closest_point #(
  parameter int unsigned POS_WIDTH = slcp_pkg::POS_WIDTH_DEF,
  parameter int unsigned DIR_WIDTH = slcp_pkg::DIR_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  slcp_in_if.sink    trk_i,
  slcp_out_if.source hit_o
);

  localparam int unsigned NW = 3 * DIR_WIDTH + POS_WIDTH + 6;
  localparam int unsigned EW = 4 * DIR_WIDTH + 5;
  localparam int unsigned FW = NW + EW + 3 * DIR_WIDTH + 3 * POS_WIDTH;

  logic          push_valid, push_ready;
  logic [FW-1:0] push_data;
  logic          pop_valid, pop_ready;
  logic [FW-1:0] pop_data;

  slcp_front #(.POS_WIDTH(POS_WIDTH), .DIR_WIDTH(DIR_WIDTH), .FW(FW)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .trk_i        (trk_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  slcp_fifo #(.WIDTH(FW)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  slcp_back #(.POS_WIDTH(POS_WIDTH), .DIR_WIDTH(DIR_WIDTH), .FW(FW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .hit_o       (hit_o)
  );

endmodule
